// File: rtl/cgn_pkg.sv
// shared types, constants and helpers for the coverage grid nearest-unvisited search
// no dependencies; used by cgn_ram users and the top level by scoped names

package cgn_pkg;

  // grid capacity
  localparam int MAX_ROWS = 32;
  localparam int MAX_COLS = 32;

  localparam int ROW_AW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int COL_AW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

  // field and datapath widths
  localparam int POS_W  = 11;  // signed position in cm
  localparam int CELL_W = 8;   // signed cell coordinate, |pos|/10 <= 102
  localparam int CNT_W  = 6;   // row and column counters, config width
  localparam int DIFF_W = 9;   // signed cell difference
  localparam int DIST_W = 16;  // squared distance
  localparam int OUT_W  = 5;   // near_row / near_col width

  // register saturation caps
  localparam logic [CNT_W-1:0] ROWS_CAP = (MAX_ROWS > 63) ? CNT_W'(63) : CNT_W'(MAX_ROWS);
  localparam logic [CNT_W-1:0] COLS_CAP = (MAX_COLS > 63) ? CNT_W'(63) : CNT_W'(MAX_COLS);

  // register indexes
  localparam logic REG_ROWS = 1'b0;
  localparam logic REG_COLS = 1'b1;

  // commands
  localparam logic CMD_MARK = 1'b0;
  localparam logic CMD_FIND = 1'b1;

  // divide by 10 through reciprocal 205/2048, exact for magnitudes up to 1024
  localparam int DIV10_MUL = 205;
  localparam int DIV10_SH  = 11;

  typedef enum logic [2:0] {
    ST_CLR,
    ST_IDLE,
    ST_CONV,
    ST_MK_RD,
    ST_MK_WR,
    ST_ROW,
    ST_COL,
    ST_FIN
  } state_e;

  // centimetres to cell, truncating toward zero
  function automatic logic signed [CELL_W-1:0] cm_to_cell(input logic signed [POS_W-1:0] v);
    logic [POS_W-1:0]     mag;
    logic [POS_W+7:0]     prod;
    logic [CELL_W-1:0]    q;
    mag  = v[POS_W-1] ? POS_W'(-v) : POS_W'(v);
    prod = (POS_W+8)'(mag) * (POS_W+8)'(DIV10_MUL);
    q    = prod[DIV10_SH +: CELL_W];
    return v[POS_W-1] ? $signed(CELL_W'(-q)) : $signed(q);
  endfunction

endpackage

// File: rtl/cgn_ram.sv
// generic single write port, single read port ram with registered read
// no dependencies

module cgn_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                                    clk_i,
  input  logic                                    we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                        wdata_i,
  input  logic                                    re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                        rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/coverage_grid_nearest_unvisited.sv
// top level: visited-cell bitmap with nearest unvisited cell search
// depends on cgn_pkg and cgn_ram
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+------------------------------------
//  cfg     | in        | cfg_we_i                   | cfg_idx_i, cfg_data_i
//  in      | in        | in_valid_i / in_ready_o    | cmd_i, pos_x_cm_i, pos_y_cm_i
//  out     | out       | out_valid_o / out_ready_i  | found_o, near_row_o, near_col_o
//
// a mark request passes through accept, convert, row read and row write
// a find request scans every cell in use: one shared squarer visits one
//   cell per cycle, and each row first takes a step for the row read and its dx term
// after reset the map is cleared one row per cycle before any request
// a finished find waits in the output register; marks go on meanwhile, a second find
//   holds in its last step until the output is taken

module coverage_grid_nearest_unvisited (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic                                cfg_idx_i,
  input  logic [cgn_pkg::CNT_W-1:0]           cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic                                cmd_i,
  input  logic signed [cgn_pkg::POS_W-1:0]    pos_x_cm_i,
  input  logic signed [cgn_pkg::POS_W-1:0]    pos_y_cm_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic                                found_o,
  output logic [cgn_pkg::OUT_W-1:0]           near_row_o,
  output logic [cgn_pkg::OUT_W-1:0]           near_col_o
);

  localparam int ROW_AW = cgn_pkg::ROW_AW;
  localparam int COL_AW = cgn_pkg::COL_AW;
  localparam int CNT_W  = cgn_pkg::CNT_W;
  localparam int CELL_W = cgn_pkg::CELL_W;
  localparam int DIFF_W = cgn_pkg::DIFF_W;
  localparam int DIST_W = cgn_pkg::DIST_W;
  localparam int OUT_W  = cgn_pkg::OUT_W;
  localparam int POS_W  = cgn_pkg::POS_W;

  cgn_pkg::state_e state_q, state_d;

  logic [ROW_AW-1:0]        clr_q, clr_d;
  logic [CNT_W-1:0]         rows_q, cols_q;
  logic                     cmd_q;
  logic signed [POS_W-1:0]  px_q, py_q;
  logic signed [CELL_W-1:0] cx_q, cx_d, cy_q, cy_d;
  logic [CNT_W-1:0]         row_q, row_d, col_q, col_d;
  logic [DIST_W-1:0]        dx2_q, dx2_d, best_q, best_d;
  logic [CNT_W-1:0]         br_q, br_d, bc_q, bc_d;
  logic                     hit_q, hit_d;
  logic                     out_valid_q, out_valid_d;
  logic                     out_found_q, out_found_d;
  logic [OUT_W-1:0]         out_row_q, out_row_d, out_col_q, out_col_d;

  logic [CNT_W-1:0]         rows_eff, cols_eff;
  logic                     accept;

  // map ram signals
  logic                     ram_we, ram_re;
  logic [ROW_AW-1:0]        ram_waddr, ram_raddr;
  logic [cgn_pkg::MAX_COLS-1:0] ram_wdata, ram_rdata;

  // shared squarer
  logic signed [DIFF_W-1:0]   sq_op;
  logic signed [2*DIFF_W-1:0] sq_full;
  logic [DIST_W-1:0]          sq;
  logic [DIST_W-1:0]          cell_dist;
  logic [COL_AW-1:0]          col_idx;
  logic                       cell_seen;

  assign rows_eff = (rows_q > cgn_pkg::ROWS_CAP) ? cgn_pkg::ROWS_CAP : rows_q;
  assign cols_eff = (cols_q > cgn_pkg::COLS_CAP) ? cgn_pkg::COLS_CAP : cols_q;

  assign in_ready_o = (state_q == cgn_pkg::ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  assign sq_op = (state_q == cgn_pkg::ST_ROW)
               ? $signed({3'b000, row_q}) - $signed({cx_q[CELL_W-1], cx_q})
               : $signed({3'b000, col_q}) - $signed({cy_q[CELL_W-1], cy_q});
  assign sq_full   = sq_op * sq_op;
  assign sq        = sq_full[DIST_W-1:0];
  assign cell_dist = dx2_q + sq;
  assign col_idx   = COL_AW'(col_q);
  assign cell_seen = ram_rdata[col_idx];

  cgn_ram #(
    .WIDTH (cgn_pkg::MAX_COLS),
    .DEPTH (cgn_pkg::MAX_ROWS)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= cgn_pkg::ST_CLR;
      clr_q       <= '0;
      rows_q      <= CNT_W'(12);
      cols_q      <= CNT_W'(20);
      out_valid_q <= 1'b0;
      hit_q       <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
      hit_q       <= hit_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          cgn_pkg::REG_ROWS: rows_q <= cfg_data_i;
          cgn_pkg::REG_COLS: cols_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= cmd_i;
      px_q  <= pos_x_cm_i;
      py_q  <= pos_y_cm_i;
    end
    cx_q        <= cx_d;
    cy_q        <= cy_d;
    row_q       <= row_d;
    col_q       <= col_d;
    dx2_q       <= dx2_d;
    best_q      <= best_d;
    br_q        <= br_d;
    bc_q        <= bc_d;
    out_found_q <= out_found_d;
    out_row_q   <= out_row_d;
    out_col_q   <= out_col_d;
  end

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    cx_d        = cx_q;
    cy_d        = cy_q;
    row_d       = row_q;
    col_d       = col_q;
    dx2_d       = dx2_q;
    best_d      = best_q;
    br_d        = br_q;
    bc_d        = bc_q;
    hit_d       = hit_q;
    out_found_d = out_found_q;
    out_row_d   = out_row_q;
    out_col_d   = out_col_q;
    out_valid_d = out_valid_q && !out_ready_i;
    ram_we      = 1'b0;
    ram_waddr   = ROW_AW'(cx_q[CELL_W-2:0]);
    ram_wdata   = ram_rdata | (cgn_pkg::MAX_COLS'(1) << COL_AW'(cy_q[CELL_W-2:0]));
    ram_re      = 1'b0;
    ram_raddr   = ROW_AW'(row_q);

    unique case (state_q)
      cgn_pkg::ST_CLR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = '0;
        clr_d     = clr_q + ROW_AW'(1);
        if (clr_q == ROW_AW'(cgn_pkg::MAX_ROWS - 1)) begin
          state_d = cgn_pkg::ST_IDLE;
        end
      end
      cgn_pkg::ST_IDLE: begin
        if (accept) begin
          state_d = cgn_pkg::ST_CONV;
        end
      end
      cgn_pkg::ST_CONV: begin
        cx_d  = cgn_pkg::cm_to_cell(px_q);
        cy_d  = cgn_pkg::cm_to_cell(py_q);
        row_d = '0;
        col_d = '0;
        hit_d = 1'b0;
        if (cmd_q == cgn_pkg::CMD_MARK) begin
          // marks outside the grid in use are dropped
          if (!cx_d[CELL_W-1] && (cx_d[CELL_W-2:0] < {1'b0, rows_eff}) &&
              !cy_d[CELL_W-1] && (cy_d[CELL_W-2:0] < {1'b0, cols_eff})) begin
            state_d = cgn_pkg::ST_MK_RD;
          end else begin
            state_d = cgn_pkg::ST_IDLE;
          end
        end else if ((rows_eff == '0) || (cols_eff == '0)) begin
          state_d = cgn_pkg::ST_FIN;
        end else begin
          state_d = cgn_pkg::ST_ROW;
        end
      end
      cgn_pkg::ST_MK_RD: begin
        ram_re    = 1'b1;
        ram_raddr = ROW_AW'(cx_q[CELL_W-2:0]);
        state_d   = cgn_pkg::ST_MK_WR;
      end
      cgn_pkg::ST_MK_WR: begin
        ram_we  = 1'b1;
        state_d = cgn_pkg::ST_IDLE;
      end
      cgn_pkg::ST_ROW: begin
        // row read and dx squared share this cycle
        ram_re  = 1'b1;
        dx2_d   = sq;
        col_d   = '0;
        state_d = cgn_pkg::ST_COL;
      end
      cgn_pkg::ST_COL: begin
        if (!cell_seen && (!hit_q || (cell_dist < best_q))) begin
          hit_d  = 1'b1;
          best_d = cell_dist;
          br_d   = row_q;
          bc_d   = col_q;
        end
        if (col_q == cols_eff - CNT_W'(1)) begin
          if (row_q == rows_eff - CNT_W'(1)) begin
            state_d = cgn_pkg::ST_FIN;
          end else begin
            row_d   = row_q + CNT_W'(1);
            state_d = cgn_pkg::ST_ROW;
          end
        end else begin
          col_d = col_q + CNT_W'(1);
        end
      end
      cgn_pkg::ST_FIN: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_found_d = hit_q;
          out_row_d   = hit_q ? br_q[OUT_W-1:0] : '0;
          out_col_d   = hit_q ? bc_q[OUT_W-1:0] : '0;
          state_d     = cgn_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = cgn_pkg::ST_IDLE;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign found_o     = out_found_q;
  assign near_row_o  = out_row_q;
  assign near_col_o  = out_col_q;

  // a not-found result carries zero coordinates
  a_notfound_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !found_o) |-> ((near_row_o == '0) && (near_col_o == '0)))
    else $error("not-found result with nonzero coordinates");

  // a found cell lies inside the grid in use
  a_found_inside : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && found_o) |-> (({1'b0, near_row_o} < rows_eff) &&
                                  ({1'b0, near_col_o} < cols_eff)))
    else $error("found cell outside grid in use");

  // the map is never written while a search walks it
  a_no_write_in_scan : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == cgn_pkg::ST_ROW) || (state_q == cgn_pkg::ST_COL)) |-> !ram_we)
    else $error("map write during search");

  // the column walk stays inside the rows and columns in use
  a_col_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == cgn_pkg::ST_COL) |-> ((col_q < cols_eff) && (row_q < rows_eff)))
    else $error("scan index out of range");

  // a row read is always followed by its column walk
  a_row_then_col : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == cgn_pkg::ST_ROW) |=> (state_q == cgn_pkg::ST_COL))
    else $error("row read not followed by column walk");

endmodule
